@@ sv/bpe_pkg.sv @@
// bpe_pkg: shared types, widths and constants of the bezier point evaluator
// no dependencies; imported by bezier_point_evaluator_core

package bpe_pkg;

    localparam int COORD_W = 16;
    localparam int OP_W    = 2;
    localparam int T_FRAC  = 16;
    localparam int T_W     = T_FRAC + 1;
    localparam int SQ_W    = 2 * T_FRAC + 1;
    localparam int CU_W    = 3 * T_FRAC + 1;
    localparam int FRAC_W  = 3 * T_FRAC;
    localparam int W_W     = FRAC_W + 1;
    localparam int LO_W    = 25;
    localparam int HI_W    = W_W - LO_W;
    localparam int PP_W    = LO_W + COORD_W;
    localparam int ACC_W   = PP_W + 2;
    localparam int SUM_W   = FRAC_W + COORD_W;
    localparam int NPTS    = 4;
    localparam int NAXES   = 2;
    localparam int STAGES  = 8;

    localparam logic [T_W-1:0]   T_ONE      = T_W'(1) << T_FRAC;
    localparam logic [W_W+1:0]   W_SUM_ONE  = (W_W + 2)'(1) << FRAC_W;
    localparam logic [SUM_W-1:0] TRUNC_BIAS = (SUM_W'(1) << FRAC_W) - SUM_W'(1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [OP_W-1:0] {
        OP_LINEAR = 2'd0,
        OP_QUAD   = 2'd1,
        OP_CUBIC  = 2'd2
    } op_t;

endpackage

@@ sv/bezier_point_evaluator_core.sv @@
// bezier_point_evaluator_core: linear, quadratic and cubic bezier point, exact fixed point
// uses bpe_pkg; each input beat passes through the stages below in order to the result beat
// throughput one beat per cycle while m_ready is high; each stage holds while the next is full and stalled
// stages: clamp, squares, cubes, weight select, split multiplies, partial sums, merge, truncate
// aresetn (synchronous, active low) clears the stage valid bits only; payload is not reset

module bezier_point_evaluator_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [bpe_pkg::OP_W-1:0]  s_operation,
    input  logic [bpe_pkg::T_W-1:0]   s_t,
    input  bpe_pkg::coord_t           s_p0_x,
    input  bpe_pkg::coord_t           s_p0_y,
    input  bpe_pkg::coord_t           s_p1_x,
    input  bpe_pkg::coord_t           s_p1_y,
    input  bpe_pkg::coord_t           s_p2_x,
    input  bpe_pkg::coord_t           s_p2_y,
    input  bpe_pkg::coord_t           s_p3_x,
    input  bpe_pkg::coord_t           s_p3_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bpe_pkg::coord_t           m_curve_x,
    output bpe_pkg::coord_t           m_curve_y
);

    import bpe_pkg::*;

    logic [STAGES-1:0] vld_reg, vld_next, en;

    // stage a: clamped t and s = 1 - t
    op_t             op_a_reg, op_a_next;
    logic [T_W-1:0]  t_a_reg, t_a_next, s_a_reg, s_a_next;
    coord_t          pt_a_reg [NAXES][NPTS];
    coord_t          pt_a_next [NAXES][NPTS];

    // stage b: second order products
    op_t             op_b_reg;
    logic [T_W-1:0]  t_b_reg, s_b_reg;
    logic [SQ_W-1:0] ss_b_reg, st_b_reg, tt_b_reg;
    logic [SQ_W-1:0] ss_b_next, st_b_next, tt_b_next;
    coord_t          pt_b_reg [NAXES][NPTS];

    // stage c: third order products
    op_t             op_c_reg;
    logic [T_W-1:0]  t_c_reg, s_c_reg;
    logic [SQ_W-1:0] ss_c_reg, st_c_reg, tt_c_reg;
    logic [CU_W-1:0] sss_c_reg, sst_c_reg, stt_c_reg, ttt_c_reg;
    logic [CU_W-1:0] sss_c_next, sst_c_next, stt_c_next, ttt_c_next;
    coord_t          pt_c_reg [NAXES][NPTS];

    // stage d: bernstein weights scaled to 2^FRAC_W
    logic [W_W-1:0]  w_d_reg [NPTS];
    logic [W_W-1:0]  w_d_next [NPTS];
    coord_t          pt_d_reg [NAXES][NPTS];
    logic [W_W+1:0]  wsum_d;

    // stage e: split weight times coordinate
    logic signed [PP_W-1:0] lo_e_reg [NAXES][NPTS];
    logic signed [PP_W-1:0] hi_e_reg [NAXES][NPTS];
    logic signed [PP_W-1:0] lo_e_next [NAXES][NPTS];
    logic signed [PP_W-1:0] hi_e_next [NAXES][NPTS];

    // stage f: partial sums
    logic signed [ACC_W-1:0] lo_f_reg [NAXES];
    logic signed [ACC_W-1:0] hi_f_reg [NAXES];
    logic signed [ACC_W-1:0] lo_f_next [NAXES];
    logic signed [ACC_W-1:0] hi_f_next [NAXES];

    // stage g: full weighted sum
    logic signed [SUM_W-1:0] tot_g_reg [NAXES];
    logic signed [SUM_W-1:0] tot_g_next [NAXES];

    // stage h: output register
    coord_t          curve_h_reg [NAXES];
    coord_t          curve_h_next [NAXES];
    logic [SUM_W-1:0] biased [NAXES];

    // stall chain
    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_ready   = en[0];
    assign m_valid   = vld_reg[STAGES-1];
    assign m_curve_x = curve_h_reg[0];
    assign m_curve_y = curve_h_reg[1];

    always_comb begin
        op_a_next = op_t'(s_operation);
        t_a_next  = (s_t > T_ONE) ? T_ONE : s_t;
        s_a_next  = T_ONE - t_a_next;
        pt_a_next[0][0] = s_p0_x;
        pt_a_next[1][0] = s_p0_y;
        pt_a_next[0][1] = s_p1_x;
        pt_a_next[1][1] = s_p1_y;
        pt_a_next[0][2] = s_p2_x;
        pt_a_next[1][2] = s_p2_y;
        pt_a_next[0][3] = s_p3_x;
        pt_a_next[1][3] = s_p3_y;
    end

    always_comb begin
        ss_b_next = SQ_W'(s_a_reg) * SQ_W'(s_a_reg);
        st_b_next = SQ_W'(s_a_reg) * SQ_W'(t_a_reg);
        tt_b_next = SQ_W'(t_a_reg) * SQ_W'(t_a_reg);
    end

    always_comb begin
        sss_c_next = CU_W'(ss_b_reg) * CU_W'(s_b_reg);
        sst_c_next = CU_W'(ss_b_reg) * CU_W'(t_b_reg);
        stt_c_next = CU_W'(tt_b_reg) * CU_W'(s_b_reg);
        ttt_c_next = CU_W'(tt_b_reg) * CU_W'(t_b_reg);
    end

    always_comb begin
        unique case (op_c_reg)
            OP_LINEAR: begin
                w_d_next[0] = W_W'(s_c_reg) << (FRAC_W - T_FRAC);
                w_d_next[1] = W_W'(t_c_reg) << (FRAC_W - T_FRAC);
                w_d_next[2] = '0;
                w_d_next[3] = '0;
            end
            OP_QUAD: begin
                w_d_next[0] = W_W'(ss_c_reg) << (FRAC_W - 2 * T_FRAC);
                w_d_next[1] = W_W'(st_c_reg) << (FRAC_W - 2 * T_FRAC + 1);
                w_d_next[2] = W_W'(tt_c_reg) << (FRAC_W - 2 * T_FRAC);
                w_d_next[3] = '0;
            end
            default: begin
                w_d_next[0] = W_W'(sss_c_reg);
                w_d_next[1] = W_W'(sst_c_reg) + (W_W'(sst_c_reg) << 1);
                w_d_next[2] = W_W'(stt_c_reg) + (W_W'(stt_c_reg) << 1);
                w_d_next[3] = W_W'(ttt_c_reg);
            end
        endcase
    end

    assign wsum_d = (W_W + 2)'(w_d_reg[0]) + (W_W + 2)'(w_d_reg[1])
                  + (W_W + 2)'(w_d_reg[2]) + (W_W + 2)'(w_d_reg[3]);

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            for (int i = 0; i < NPTS; i++) begin
                lo_e_next[a][i] = PP_W'($signed({1'b0, w_d_reg[i][LO_W-1:0]}))
                                * PP_W'(pt_d_reg[a][i]);
                hi_e_next[a][i] = PP_W'($signed({1'b0, w_d_reg[i][W_W-1:LO_W]}))
                                * PP_W'(pt_d_reg[a][i]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            lo_f_next[a] = '0;
            hi_f_next[a] = '0;
            for (int i = 0; i < NPTS; i++) begin
                lo_f_next[a] = lo_f_next[a] + ACC_W'(lo_e_reg[a][i]);
                hi_f_next[a] = hi_f_next[a] + ACC_W'(hi_e_reg[a][i]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            tot_g_next[a] = (SUM_W'(hi_f_reg[a]) <<< LO_W) + SUM_W'(lo_f_reg[a]);
        end
    end

    // truncate toward zero
    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            biased[a] = tot_g_reg[a] + (tot_g_reg[a][SUM_W-1] ? TRUNC_BIAS : '0);
            curve_h_next[a] = biased[a][SUM_W-1 -: COORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            op_a_reg <= op_a_next;
            t_a_reg  <= t_a_next;
            s_a_reg  <= s_a_next;
            pt_a_reg <= pt_a_next;
        end
        if (en[1]) begin
            op_b_reg <= op_a_reg;
            t_b_reg  <= t_a_reg;
            s_b_reg  <= s_a_reg;
            ss_b_reg <= ss_b_next;
            st_b_reg <= st_b_next;
            tt_b_reg <= tt_b_next;
            pt_b_reg <= pt_a_reg;
        end
        if (en[2]) begin
            op_c_reg  <= op_b_reg;
            t_c_reg   <= t_b_reg;
            s_c_reg   <= s_b_reg;
            ss_c_reg  <= ss_b_reg;
            st_c_reg  <= st_b_reg;
            tt_c_reg  <= tt_b_reg;
            sss_c_reg <= sss_c_next;
            sst_c_reg <= sst_c_next;
            stt_c_reg <= stt_c_next;
            ttt_c_reg <= ttt_c_next;
            pt_c_reg  <= pt_b_reg;
        end
        if (en[3]) begin
            w_d_reg  <= w_d_next;
            pt_d_reg <= pt_c_reg;
        end
        if (en[4]) begin
            lo_e_reg <= lo_e_next;
            hi_e_reg <= hi_e_next;
        end
        if (en[5]) begin
            lo_f_reg <= lo_f_next;
            hi_f_reg <= hi_f_next;
        end
        if (en[6]) begin
            tot_g_reg <= tot_g_next;
        end
        if (en[7]) begin
            curve_h_reg <= curve_h_next;
        end
    end

    a_clamp_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> ((T_W + 1)'(t_a_reg) + (T_W + 1)'(s_a_reg) == (T_W + 1)'(T_ONE)))
        else $error("clamped t and s do not sum to one");

    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (wsum_d == W_SUM_ONE))
        else $error("bernstein weights do not sum to one");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_ready) |-> (!s_ready ##1 &vld_reg))
        else $error("full pipeline lost an item under output stall");

endmodule
